### design/osd_pkg.sv
// Shared types, constants and glyph table of the on-screen text overlay.
// No dependencies; every other file of the block imports this package.
package osd_pkg;

  localparam int MAX_CHARS_DEF = 64;
  localparam int MAX_LINES_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int NUM_GLYPHS    = 40;
  localparam int GLYPH_CELLS   = 56;
  localparam int CFG_IW        = 2;
  localparam int CFG_DW        = 13;
  localparam int XW            = 14;

  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_LOWER_N   = 8'd110;

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_X,
    CFG_START_Y,
    CFG_FRAME_WIDTH,
    CFG_BIG_FONT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_PIXEL,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_code;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  luma_in;
  } item_t;

  typedef struct packed {
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [12:0] frame_width;
    logic        big_font;
  } cfg_t;

  // Each glyph is 8 rows of 7 cells, one ASCII digit per cell: 0 clear, 1 outline, 2 body
  localparam logic [8*GLYPH_CELLS-1:0] GLYPH_ROM [NUM_GLYPHS] = '{
    "00000000000000000000000000000000000000000000000000000000",
    "00111000122210121122112121211212121122112101222100011100",
    "00010000012100012210000121000012100001210001222100011100",
    "00111000122210121112101122100121100121111012222210111110",
    "00111000122210121112101122100101121121112101222100011100",
    "00001000001210001221001212101222221011121000012100000100",
    "01111101222221121111012222100111120011112012222100111100",
    "00111100122221121111012222101211121121112101222100011100",
    "01111101222221011112100012100012100012100001210000010000",
    "00111000122210121112101222101211121121112101222100011100",
    "00111000122210121112101222210111121121112101222100011100",
    "00110000122100012210000110000011000012210001221000011000",
    "00000000000000001110001222100011100000000000000000000000",
    "00010000012100012100001210000121000012100000121000001000",
    "00010000012100000121000012100001210000121000012100001000",
    "00111000122210121112112111211222221121112112101210100010",
    "01111001222210121112112222101211121121112112222100111100",
    "00111000122210121112112100101210010121112101222100011100",
    "01111001222210121112112101211210121121112112222100111100",
    "01111101222221121111012222101211100121111012222210111110",
    "01111101222221121111012222101211100121000012100000100000",
    "00111000122210121112112111101212221121112101222100011100",
    "01000101210121121112112222211211121121012112101210100010",
    "00111000122210001210000121000012100001210001222100011100",
    "00111100122221001112100001210100121121112101222100011100",
    "01000101210121121121012121001222100121121012101210100010",
    "01000001210000121000012100001210000121110012222100111100",
    "01101101221221121212112111211210121121012112101210100010",
    "01000101210121122112112121211211221121012112101210100010",
    "00111000122210121112112101211210121121112101222100011100",
    "01111001222210121112112222101211100121000012100000100000",
    "01111001222210121112112222101212100121121012101210100010",
    "00111100122221121111001222100011121011112112222100111100",
    "01111101222221011211000121000012100001210000121000001000",
    "01000101210121121012112101211210121121112101222210011110",
    "01000101210121121012112101211210121012121000121000001000",
    "01000101210121121012112111211212121121212101212100010100",
    "01000101210121012121000121000012100012121012101210100010",
    "01000101210121012121000121000012100001210000121000001000",
    "01111101222221011121000121000121000121111012222210111110"
  };

  // Map a character code to its glyph; codes without a glyph give the blank one
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [5:0] g;
    g = '0;
    if (code >= "0" && code <= "9") g = 6'(code - "0") + 6'd1;
    else if (code == ":") g = 6'd11;
    else if (code == "-") g = 6'd12;
    else if (code == "(") g = 6'd13;
    else if (code == ")") g = 6'd14;
    else if (code >= "A" && code <= "P") g = 6'(code - "A") + 6'd15;
    else if (code >= "R" && code <= "Z") g = 6'(code - "R") + 6'd31;
    return g;
  endfunction

  // Fetch one 2-bit cell of the glyph of a character
  function automatic logic [1:0] glyph_cell(input logic [7:0] code, input logic [2:0] row,
                                            input logic [2:0] col);
    logic [5:0] g;
    logic [5:0] pos;
    logic [8:0] sh;
    logic [7:0] ch;
    g   = glyph_index(code);
    pos = {row, 3'b000} - {3'b000, row} + {3'b000, col};
    sh  = {6'd55 - pos, 3'b000};
    ch  = GLYPH_ROM[g][sh +: 8];
    return ch[1:0];
  endfunction

endpackage

### design/osd_text_overlay.sv
// Top level of the on-screen text overlay: configuration registers, front
// queue and back pipeline. Depends on osd_pkg, osd_front and osd_back.
//
// The block takes one item per clock while the output is not stalled, text
// loads and pixels alike, and gives one result per pixel item. A two-entry
// queue parts the input from a five-stage back pipeline; the rate is set by
// the text store, which serves one write and the two character reads of a
// pixel in the same stage each cycle that the back pipeline advances. A stall
// at the output holds the whole back pipeline. The store needs no clearing
// pass: only characters that were written are ever used. Configuration is
// written with cfg_we_i, cfg_index_i and cfg_data_i; the user must write it
// only while the block is idle, as the block itself does not enforce it.
module osd_text_overlay import osd_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        char_code_i,
  input  logic [11:0]       pixel_x_i,
  input  logic [11:0]       pixel_y_i,
  input  logic [7:0]        luma_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        luma_out_o,
  output logic              text_hit_o
);

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x     <= '0;
      cfg_q.start_y     <= '0;
      cfg_q.frame_width <= 13'd1920;
      cfg_q.big_font    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_START_X:     cfg_q.start_x     <= cfg_data_i[11:0];
        CFG_START_Y:     cfg_q.start_y     <= cfg_data_i[11:0];
        CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data_i;
        CFG_BIG_FONT:    cfg_q.big_font    <= cfg_data_i[0];
      endcase
    end
  end

  assign in_item.kind      = kind_e'(kind_i);
  assign in_item.char_code = char_code_i;
  assign in_item.pixel_x   = pixel_x_i;
  assign in_item.pixel_y   = pixel_y_i;
  assign in_item.luma_in   = luma_in_i;

  osd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .q_pop_i    (q_pop),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  osd_back #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_LINES (MAX_LINES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .luma_out_o  (luma_out_o),
    .text_hit_o  (text_hit_o)
  );

`ifndef NO_ASSERTIONS
  // A transferred text or pixel item is waiting in the queue next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i != KIND_NONE)) |=> q_valid)
    else $error("accepted item missing from queue");

  // A glyph hit forces the luma to outline black or body white
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_hit_o) |-> ((luma_out_o == 8'd0) || (luma_out_o == 8'd255)))
    else $error("text hit with pass-through luma");

  // The queue is popped only when it holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

### design/osd_front.sv
// Front end of the text overlay: accepts items, drops the unused kind and
// queues the rest for the back end. Depends on osd_pkg.
module osd_front import osd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  q_pop_i,
  output logic  q_valid_o,
  output item_t q_item_o
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t             q_mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  // Classify: only clear, append and pixel items enter the queue
  assign in_ready_o = (cnt_q != CNTW'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o && (in_item_i.kind != KIND_NONE);
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = q_mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) cnt_d = cnt_q + CNTW'(1);
    else if (pop && !push) cnt_d = cnt_q - CNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= in_item_i;
  end

endmodule

### design/osd_back.sv
// Back end of the text overlay: text state, line placement pipeline, text
// store and glyph lookup, ending in the output register. Depends on osd_pkg.
module osd_back import osd_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] luma_out_o,
  output logic       text_hit_o
);

  localparam int AW  = $clog2(MAX_CHARS);
  localparam int CW  = $clog2(MAX_CHARS + 1);
  localparam int LIW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LCW = $clog2(MAX_LINES + 1);
  localparam int KW  = 10;
  localparam logic [12:0] RECIP3 = 13'd2731;

  typedef struct packed {
    logic [7:0]    luma;
    logic [11:0]   px;
    logic          ok;
    logic [2:0]    row;
    logic [CW-1:0] len;
    logic [AW-1:0] first;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
  } s1_t;

  typedef struct packed {
    logic [7:0]    luma;
    logic          ok;
    logic [11:0]   dx;
    logic [12:0]   lim;
    logic          clip;
    logic [2:0]    row;
    logic [CW-1:0] len;
    logic [AW-1:0] first;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
  } s2_t;

  typedef struct packed {
    logic [7:0]    luma;
    logic          ok;
    logic [11:0]   dx;
    logic [12:0]   lim;
    logic          clip;
    logic [2:0]    row;
    logic [CW-1:0] len;
    logic [AW-1:0] first;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [KW-1:0] k;
  } s3_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       ok0;
    logic       ok1;
    logic [2:0] row;
    logic [2:0] col0;
  } s4_t;

  // Text state
  logic [CW-1:0]  char_count_q, char_count_d;
  logic [LCW-1:0] line_count_q, line_count_d;
  logic           after_bs_q, after_bs_d;
  logic [AW-1:0]  line_first_q  [MAX_LINES];
  logic [AW-1:0]  line_first_d  [MAX_LINES];
  logic [CW-1:0]  line_length_q [MAX_LINES];
  logic [CW-1:0]  line_length_d [MAX_LINES];

  logic [7:0] text_mem [MAX_CHARS];
  logic [7:0] rd0_q, rd1_q;

  logic en, pop, is_pix, we_d;
  logic pv1_q, pv2_q, pv3_q, pv4_q;
  logic we1_q, we2_q, we3_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  logic [AW-1:0] a0, a1;
  logic       out_valid_q;
  logic [7:0] luma_q, luma_d;
  logic       hit_q, hit_d;

  assign en      = !out_valid_q || out_ready_i;
  assign pop     = en && q_valid_i;
  assign q_pop_o = pop;
  assign is_pix  = (q_item_i.kind == KIND_PIXEL);

  // Update text state on clear and append
  always_comb begin
    logic [LIW-1:0] cur;
    logic           brk;
    char_count_d  = char_count_q;
    line_count_d  = line_count_q;
    after_bs_d    = after_bs_q;
    line_first_d  = line_first_q;
    line_length_d = line_length_q;
    we_d          = 1'b0;
    cur = LIW'(line_count_q - LCW'(1));
    brk = after_bs_q && (q_item_i.char_code == CH_LOWER_N) &&
          (line_count_q < LCW'(MAX_LINES));
    if (pop) begin
      unique case (q_item_i.kind)
        KIND_CLEAR: begin
          char_count_d = '0;
          line_count_d = LCW'(1);
          after_bs_d   = 1'b0;
          for (int l = 0; l < MAX_LINES; l++) begin
            line_first_d[l]  = '0;
            line_length_d[l] = '0;
          end
        end
        KIND_APPEND: begin
          priority if (brk) begin
            // Drop the stored backslash and open a new line
            if (line_length_q[cur] != '0) line_length_d[cur] = line_length_q[cur] - CW'(1);
            if (char_count_q != '0) char_count_d = char_count_q - CW'(1);
            line_first_d[LIW'(line_count_q)]  = AW'(char_count_d);
            line_length_d[LIW'(line_count_q)] = '0;
            line_count_d = line_count_q + LCW'(1);
            after_bs_d   = 1'b0;
          end else if (char_count_q >= CW'(MAX_CHARS)) begin
            after_bs_d = 1'b0;
          end else begin
            we_d               = 1'b1;
            char_count_d       = char_count_q + CW'(1);
            line_length_d[cur] = line_length_q[cur] + CW'(1);
            after_bs_d         = (q_item_i.char_code == CH_BACKSLASH);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      line_count_q <= LCW'(1);
      after_bs_q   <= 1'b0;
      for (int l = 0; l < MAX_LINES; l++) begin
        line_first_q[l]  <= '0;
        line_length_q[l] <= '0;
      end
    end else begin
      char_count_q  <= char_count_d;
      line_count_q  <= line_count_d;
      after_bs_q    <= after_bs_d;
      line_first_q  <= line_first_d;
      line_length_q <= line_length_d;
    end
  end

  // Stage 0: find the one line whose rows cover the pixel
  always_comb begin
    logic [LCW-1:0] dl;
    logic [8:0]     up;
    logic [12:0]    top, rel;
    s1_d       = '0;
    s1_d.luma  = q_item_i.luma_in;
    s1_d.px    = q_item_i.pixel_x;
    s1_d.waddr = AW'(char_count_q);
    s1_d.wdata = q_item_i.char_code;
    for (int l = 0; l < MAX_LINES; l++) begin
      dl  = line_count_q - LCW'(1) - LCW'(l);
      up  = (9'(dl) << 3) + 9'(dl);
      if (cfg_i.big_font) up = up << 1;
      top = 13'(cfg_i.start_y) - 13'(up);
      rel = 13'(q_item_i.pixel_y) - top;
      if ((LCW'(l) < line_count_q) && (13'(cfg_i.start_y) >= 13'(up)) &&
          (13'(q_item_i.pixel_y) >= top) &&
          (rel < (cfg_i.big_font ? 13'd16 : 13'd8))) begin
        s1_d.ok    = 1'b1;
        s1_d.len   = line_length_q[l];
        s1_d.first = line_first_q[l];
        s1_d.row   = cfg_i.big_font ? rel[3:1] : rel[2:0];
      end
    end
  end

  // Stage 1: place and clip the line, column offset of the pixel
  always_comb begin
    logic [XW-1:0] span, fw, sx, px, x0;
    logic          drop;
    span = (XW'(s1_q.len) << 2) + (XW'(s1_q.len) << 1);
    if (cfg_i.big_font) span = span << 1;
    fw   = XW'(cfg_i.frame_width);
    sx   = XW'(cfg_i.start_x);
    px   = XW'(s1_q.px);
    drop = 1'b0;
    x0   = sx;
    if (sx > (fw >> 1)) begin
      if (sx < span) drop = 1'b1;
      x0 = sx - span;
    end
    s2_d.clip = ((x0 + span) >= fw);
    if (s2_d.clip && (x0 >= fw)) drop = 1'b1;
    if ((px < x0) || (px >= fw)) drop = 1'b1;
    s2_d.lim   = 13'(fw - x0 - XW'(1));
    s2_d.dx    = 12'(px - x0);
    s2_d.ok    = s1_q.ok && !drop;
    s2_d.luma  = s1_q.luma;
    s2_d.row   = s1_q.row;
    s2_d.len   = s1_q.len;
    s2_d.first = s1_q.first;
    s2_d.waddr = s1_q.waddr;
    s2_d.wdata = s1_q.wdata;
  end

  // Stage 2: character index as a reciprocal multiply by one third
  always_comb begin
    logic [10:0] dxh;
    logic [23:0] prod;
    dxh  = cfg_i.big_font ? {1'b0, s2_q.dx[11:2]} : s2_q.dx[11:1];
    prod = 24'(dxh) * 24'(RECIP3);
    s3_d.luma  = s2_q.luma;
    s3_d.ok    = s2_q.ok;
    s3_d.dx    = s2_q.dx;
    s3_d.lim   = s2_q.lim;
    s3_d.clip  = s2_q.clip;
    s3_d.row   = s2_q.row;
    s3_d.len   = s2_q.len;
    s3_d.first = s2_q.first;
    s3_d.waddr = s2_q.waddr;
    s3_d.wdata = s2_q.wdata;
    s3_d.k     = prod[KW+12:13];
  end

  // Stage 3: glyph column and which of the two overlapping characters apply
  always_comb begin
    logic [XW-1:0] ks, sw, kx, lx;
    logic [3:0]    rem;
    sw  = cfg_i.big_font ? XW'(12) : XW'(6);
    ks  = (XW'(s3_q.k) << 2) + (XW'(s3_q.k) << 1);
    if (cfg_i.big_font) ks = ks << 1;
    rem = 4'(XW'(s3_q.dx) - ks);
    kx  = XW'(s3_q.k);
    lx  = XW'(s3_q.lim);
    s4_d.luma = s3_q.luma;
    s4_d.row  = s3_q.row;
    s4_d.col0 = cfg_i.big_font ? rem[3:1] : rem[2:0];
    s4_d.ok0  = s3_q.ok && (kx < XW'(s3_q.len)) && (!s3_q.clip || ((ks + sw) <= lx));
    s4_d.ok1  = s3_q.ok && (kx != '0) && ((kx - XW'(1)) < XW'(s3_q.len)) &&
                (!s3_q.clip || (ks <= lx)) &&
                (cfg_i.big_font ? (rem < 4'd2) : (rem == 4'd0));
    a0 = AW'(XW'(s3_q.first) + kx);
    a1 = AW'(XW'(s3_q.first) + kx - XW'(1));
  end

  // Text store: one write and two reads, kept in order with the pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (we3_q) text_mem[s3_q.waddr] <= s3_q.wdata;
      rd0_q <= text_mem[a0];
      rd1_q <= text_mem[a1];
    end
  end

  // Stage 4: glyph cells and the luma that results
  always_comb begin
    logic [1:0] c0, c1, v;
    c0 = glyph_cell(rd0_q, s4_q.row, s4_q.col0);
    c1 = glyph_cell(rd1_q, s4_q.row, 3'd6);
    v  = 2'd0;
    if (s4_q.ok0 && (c0 != 2'd0)) v = c0;
    else if (s4_q.ok1) v = c1;
    luma_d = s4_q.luma;
    if (v == 2'd1) luma_d = 8'd0;
    else if (v == 2'd2) luma_d = 8'd255;
    hit_d = (v == 2'd1) || (v == 2'd2);
  end

  // Advance pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv1_q <= 1'b0; pv2_q <= 1'b0; pv3_q <= 1'b0; pv4_q <= 1'b0;
      we1_q <= 1'b0; we2_q <= 1'b0; we3_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pv1_q <= pop && is_pix;
      pv2_q <= pv1_q;
      pv3_q <= pv2_q;
      pv4_q <= pv3_q;
      we1_q <= we_d;
      we2_q <= we1_q;
      we3_q <= we2_q;
      out_valid_q <= pv4_q;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      s4_q   <= s4_d;
      luma_q <= luma_d;
      hit_q  <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign luma_out_o  = luma_q;
  assign text_hit_o  = hit_q;

endmodule
